[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the two-wire sensor master.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside of reset.
`define TWS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define TWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TWS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/tws_pkg.sv]
// Shared types and constants for the two-wire sensor measurement master.
// No dependencies; used by the channel interfaces and the top level.
package tws_pkg;

  localparam int CmdW      = 8;
  localparam int RawW      = 16;
  localparam int ErrW      = 2;
  localparam int BitIdxW   = 4;
  localparam int PollW     = 20;
  localparam int TimeoutW  = 22;
  localparam int SettleW   = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 22;
  localparam int PhaseW    = 17;

  localparam int WordBitsDefault = 16;

  localparam logic [PollW-1:0]    PollResetVal    = PollW'(10000);
  localparam logic [TimeoutW-1:0] TimeoutResetVal = TimeoutW'(1000 * 1000);
  localparam logic [SettleW-1:0]  SettleResetVal  = SettleW'(10);
  localparam logic [TimeoutW-1:0] ElapsedMax      = '1;

  // Last command bit and last bit of the first read byte.
  localparam logic [BitIdxW-1:0] LastCmdBit   = BitIdxW'(7);
  localparam logic [BitIdxW-1:0] LastByte0Bit = BitIdxW'(7);
  localparam logic [BitIdxW-1:0] LastWordBit  = BitIdxW'(15);

  typedef enum logic [ErrW-1:0] {
    ErrNone    = 2'd0,
    ErrAck1    = 2'd1,
    ErrAck2    = 2'd2,
    ErrTimeout = 2'd3
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPollInterval = 2'd0,
    CfgTimeout      = 2'd1,
    CfgAckSettle    = 2'd2
  } cfg_idx_e;

  typedef enum logic [PhaseW-1:0] {
    PhIdle    = 17'h00001,
    PhS1      = 17'h00002,
    PhS2      = 17'h00004,
    PhS3      = 17'h00008,
    PhS4      = 17'h00010,
    PhCmdHi   = 17'h00020,
    PhCmdLo   = 17'h00040,
    PhAck1    = 17'h00080,
    PhSettle  = 17'h00100,
    PhWait    = 17'h00200,
    PhRdA     = 17'h00400,
    PhRdB     = 17'h00800,
    PhRdC     = 17'h01000,
    PhMackHi  = 17'h02000,
    PhMackLo  = 17'h04000,
    PhCrc     = 17'h08000,
    PhDone    = 17'h10000
  } phase_e;

  // One result transaction: line levels and status for one tick.
  typedef struct packed {
    logic            clock_out;
    logic            data_pull_low;
    logic            busy_res;
    logic            done_res;
    logic [RawW-1:0] raw_value;
    logic [ErrW-1:0] error_code;
  } res_t;

endpackage

[rtl/tws_if.sv]
// Valid/ready channel interfaces of the two-wire sensor master: tick input,
// result output and configuration write. Depends on tws_pkg.
interface tws_in_if;
  import tws_pkg::*;
  logic            valid;
  logic            ready;
  logic            start_req;
  logic [CmdW-1:0] command;
  logic            data_in;

  modport source(output valid, start_req, command, data_in, input ready);
  modport sink(input valid, start_req, command, data_in, output ready);
endinterface

interface tws_out_if;
  import tws_pkg::*;
  logic            valid;
  logic            ready;
  logic            clock_out;
  logic            data_pull_low;
  logic            busy_res;
  logic            done_res;
  logic [RawW-1:0] raw_value;
  logic [ErrW-1:0] error_code;

  modport source(output valid, clock_out, data_pull_low, busy_res, done_res, raw_value,
                 error_code, input ready);
  modport sink(input valid, clock_out, data_pull_low, busy_res, done_res, raw_value,
               error_code, output ready);
endinterface

interface tws_cfg_if;
  import tws_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/two_wire_sensor_transaction.sv]
// Bit-level measurement master for a two-wire humidity/temperature sensor.
// Depends on tws_pkg, the channel interfaces in tws_if.sv and assert_macros.svh.
//
// Each input transaction is one timing tick (typically one microsecond): a
// start request, the command byte and the sampled level of the data line.
// Each tick produces exactly one result transaction carrying the clock level,
// the open-drain data pull-down, busy, a one-tick done pulse, the raw word
// and an error code (0 ok, 1 first ack missing, 2 ack release missing,
// 3 timeout). A start request is honored only while idle; the sequencer then
// runs the transmission start, shifts the command out MSB first, checks the
// two acknowledge samples, polls the data line every poll interval until the
// sensor pulls it low or the timeout expires, reads two bytes MSB first with
// a master acknowledge between them and skips the CRC. On an error both
// lines are released on the done tick. Throughput is one tick per clock
// cycle while the result side does not stall; each tick passes through the
// input register, the combinational sequencer update and the result register.
// While a result waits to be taken, the input side accepts one more
// transaction into the empty input register and then stalls until the
// result is taken. Configuration writes are always
// accepted and must only be issued while no transaction is in flight;
// unknown register indexes are ignored. A poll interval or settle time of
// zero behaves as one.
`include "assert_macros.svh"

module two_wire_sensor_transaction #(
  parameter int WORD_BITS = tws_pkg::WordBitsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tws_in_if.sink    in_i,
  tws_out_if.source out_o,
  tws_cfg_if.sink   cfg_i
);
  import tws_pkg::*;

  // Configuration registers.
  logic [PollW-1:0]    poll_q;
  logic [TimeoutW-1:0] timeout_q;
  logic [SettleW-1:0]  settle_q;

  // Input register stage.
  logic            in_valid_q, in_valid_d;
  logic            in_start_q;
  logic [CmdW-1:0] in_cmd_q;
  logic            in_din_q;
  logic            in_accept;
  logic            advance;

  // Sequencer state.
  phase_e               phase_q, phase_d;
  logic [BitIdxW-1:0]   bit_idx_q, bit_idx_d;
  logic [PollW-1:0]     delay_q, delay_d;
  logic [TimeoutW-1:0]  elapsed_q, elapsed_d;
  logic [CmdW-1:0]      cmd_shift_q, cmd_shift_d;
  logic [WORD_BITS-1:0] data_shift_q, data_shift_d;
  err_e                 err_q, err_d;

  // Result register stage.
  logic out_valid_q, out_valid_d;
  res_t res_q, res_d;

  logic [PollW-1:0] interval;
  logic [PollW-1:0] settle;
  logic [PollW:0]   delay_plus;
  logic             cmd_bit;

  assign cfg_i.ready = 1'b1;

  // Advance the sequencer when a tick is held and the result slot frees up.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_accept  = in_i.valid && in_i.ready;

  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Zero interval or settle time samples every tick.
  assign interval   = (poll_q == '0) ? PollW'(1) : poll_q;
  assign settle     = (settle_q == '0) ? PollW'(1) : PollW'(settle_q);
  assign delay_plus = {1'b0, delay_q} + (PollW + 1)'(1);
  assign cmd_bit    = cmd_shift_q[CmdW-1];

  // Sequencer: one tick of line control per transaction.
  always_comb begin
    phase_d      = phase_q;
    bit_idx_d    = bit_idx_q;
    delay_d      = delay_q;
    elapsed_d    = elapsed_q;
    cmd_shift_d  = cmd_shift_q;
    data_shift_d = data_shift_q;
    err_d        = err_q;
    res_d        = '0;
    res_d.busy_res = 1'b1;

    unique case (phase_q)
      PhIdle: begin
        res_d.busy_res = 1'b0;
        if (in_start_q) begin
          res_d.busy_res = 1'b1;
          cmd_shift_d    = in_cmd_q;
          bit_idx_d      = '0;
          data_shift_d   = '0;
          err_d          = ErrNone;
          phase_d        = PhS1;
        end
      end
      PhS1: begin
        res_d.clock_out     = 1'b1;
        res_d.data_pull_low = 1'b1;
        phase_d             = PhS2;
      end
      PhS2: begin
        res_d.data_pull_low = 1'b1;
        phase_d             = PhS3;
      end
      PhS3: begin
        res_d.clock_out = 1'b1;
        phase_d         = PhS4;
      end
      PhS4: begin
        bit_idx_d = '0;
        phase_d   = PhCmdHi;
      end
      PhCmdHi: begin
        res_d.clock_out     = 1'b1;
        res_d.data_pull_low = !cmd_bit;
        phase_d             = PhCmdLo;
      end
      PhCmdLo: begin
        res_d.data_pull_low = !cmd_bit;
        cmd_shift_d         = {cmd_shift_q[CmdW-2:0], 1'b0};
        if (bit_idx_q >= LastCmdBit) begin
          bit_idx_d = '0;
          phase_d   = PhAck1;
        end else begin
          bit_idx_d = bit_idx_q + BitIdxW'(1);
          phase_d   = PhCmdHi;
        end
      end
      PhAck1: begin
        res_d.clock_out = 1'b1;
        if (in_din_q) begin
          err_d   = ErrAck1;
          phase_d = PhDone;
        end else begin
          delay_d = '0;
          phase_d = PhSettle;
        end
      end
      PhSettle: begin
        if (delay_plus >= {1'b0, settle}) begin
          if (!in_din_q) begin
            err_d   = ErrAck2;
            phase_d = PhDone;
          end else begin
            delay_d   = '0;
            elapsed_d = '0;
            phase_d   = PhWait;
          end
        end else begin
          delay_d = delay_plus[PollW-1:0];
        end
      end
      PhWait: begin
        if (delay_plus >= {1'b0, interval}) begin
          delay_d = '0;
          if (!in_din_q) begin
            bit_idx_d    = '0;
            data_shift_d = '0;
            phase_d      = PhRdA;
          end else if (elapsed_q >= timeout_q) begin
            err_d   = ErrTimeout;
            phase_d = PhDone;
          end
        end else begin
          delay_d = delay_plus[PollW-1:0];
        end
        // Saturate the wait counter.
        if (elapsed_q != ElapsedMax) begin
          elapsed_d = elapsed_q + TimeoutW'(1);
        end
      end
      PhRdA: begin
        res_d.clock_out = 1'b1;
        data_shift_d    = {data_shift_q[WORD_BITS-2:0], in_din_q};
        phase_d         = PhRdB;
      end
      PhRdB: begin
        res_d.clock_out = 1'b1;
        phase_d         = PhRdC;
      end
      PhRdC: begin
        if (bit_idx_q == LastByte0Bit) begin
          phase_d = PhMackHi;
        end else if (bit_idx_q >= LastWordBit) begin
          phase_d = PhCrc;
        end else begin
          phase_d = PhRdA;
        end
        bit_idx_d = bit_idx_q + BitIdxW'(1);
      end
      PhMackHi: begin
        res_d.clock_out     = 1'b1;
        res_d.data_pull_low = 1'b1;
        phase_d             = PhMackLo;
      end
      PhMackLo: begin
        res_d.data_pull_low = 1'b1;
        phase_d             = PhRdA;
      end
      PhCrc: begin
        res_d.clock_out = 1'b1;
        err_d           = ErrNone;
        phase_d         = PhDone;
      end
      PhDone: begin
        res_d.busy_res   = 1'b0;
        res_d.done_res   = 1'b1;
        res_d.error_code = err_q;
        if (err_q == ErrNone) begin
          res_d.raw_value = RawW'(data_shift_q);
        end
        phase_d = PhIdle;
      end
      default: begin
        // Drop an illegal state back to idle.
        res_d.busy_res = 1'b0;
        phase_d        = PhIdle;
      end
    endcase
  end

  // Configuration registers: mask to width, ignore unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q    <= PollResetVal;
      timeout_q <= TimeoutResetVal;
      settle_q  <= SettleResetVal;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CfgPollInterval: poll_q    <= cfg_i.data[PollW-1:0];
        CfgTimeout:      timeout_q <= cfg_i.data[TimeoutW-1:0];
        CfgAckSettle:    settle_q  <= cfg_i.data[SettleW-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PhIdle;
      bit_idx_q    <= '0;
      delay_q      <= '0;
      elapsed_q    <= '0;
      cmd_shift_q  <= '0;
      data_shift_q <= '0;
      err_q        <= ErrNone;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q      <= phase_d;
        bit_idx_q    <= bit_idx_d;
        delay_q      <= delay_d;
        elapsed_q    <= elapsed_d;
        cmd_shift_q  <= cmd_shift_d;
        data_shift_q <= data_shift_d;
        err_q        <= err_d;
      end
    end
  end

  // Payload registers: hold the tick and the result until they move on.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_start_q <= in_i.start_req;
      in_cmd_q   <= in_i.command;
      in_din_q   <= in_i.data_in;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.clock_out     = res_q.clock_out;
  assign out_o.data_pull_low = res_q.data_pull_low;
  assign out_o.busy_res      = res_q.busy_res;
  assign out_o.done_res      = res_q.done_res;
  assign out_o.raw_value     = res_q.raw_value;
  assign out_o.error_code    = res_q.error_code;

  `TWS_ASSERT(a_done_not_busy, clk_i, rst_ni,
              (out_valid_q && res_q.done_res) |-> !res_q.busy_res,
              "done result reported busy")
  `TWS_ASSERT(a_raw_only_ok, clk_i, rst_ni,
              (out_valid_q && res_q.raw_value != '0) |->
                (res_q.done_res && res_q.error_code == ErrNone),
              "raw value outside a clean done")
  `TWS_ASSERT_NEXT(a_done_to_idle, clk_i, rst_ni,
                   (advance && phase_q == PhDone),
                   (phase_q == PhIdle && out_valid_q && res_q.done_res),
                   "done tick did not return to idle")
  `TWS_ASSERT_NEXT(a_hold_tick, clk_i, rst_ni,
                   (in_valid_q && !advance),
                   (in_valid_q && $stable(in_din_q) && $stable(in_start_q)),
                   "held tick lost while stalled")

endmodule
